// ===== rtl/core/bth_pkg.sv =====
// Shared constants, types and command codes for the boundary-tag heap allocator.
// No dependencies; every other file but bth_ram imports this package.
package bth_pkg;

    localparam int HEAP_WORDS = 1024;
    localparam int AW         = $clog2(HEAP_WORDS);
    localparam int TW         = 11;   // signed tag word
    localparam int XW         = 12;   // index arithmetic, holds sums past the heap end
    localparam int CW         = 13;   // byte statistics
    localparam int BW         = 16;   // requested byte count
    localparam int NW         = 15;   // requested word count
    localparam int CMDW       = 2;

    localparam logic [CMDW-1:0] CMD_INIT    = 2'd0;
    localparam logic [CMDW-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMDW-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMDW-1:0] CMD_RESIZE  = 2'd3;

    localparam logic [TW-1:0] INIT_TAG  = TW'(-(HEAP_WORDS - 2));
    localparam logic [CW-1:0] FREE_INIT = CW'((HEAP_WORDS - 2) * 4);
    localparam logic [CW-1:0] USED_INIT = CW'(8);

    typedef struct packed {
        logic [CMDW-1:0] cmd;
        logic [BW-1:0]   byte_count;
        logic [AW-1:0]   payload_index;
    } bth_req_t;

    typedef struct packed {
        logic          valid;
        logic          status;
        logic [AW-1:0] idx;
        logic [CW-1:0] free_b;
        logic [CW-1:0] used_b;
    } bth_done_t;

endpackage

// ===== rtl/core/bth_cmd_if.sv =====
// Command channel: valid/ready handshake with the command word.
// Depends on bth_pkg.
interface bth_cmd_if import bth_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CMDW-1:0] cmd;
    logic [BW-1:0]   byte_count;
    logic [AW-1:0]   payload_index;

    modport source (output valid, cmd, byte_count, payload_index, input ready);
    modport sink   (input valid, cmd, byte_count, payload_index, output ready);
endinterface

// ===== rtl/core/bth_res_if.sv =====
// Result channel: valid/ready handshake with the result word.
// Depends on bth_pkg.
interface bth_res_if import bth_pkg::*; ();
    logic          valid;
    logic          ready;
    logic          status;
    logic [AW-1:0] result_index;
    logic [CW-1:0] free_bytes;
    logic [CW-1:0] used_bytes;

    modport source (output valid, status, result_index, free_bytes, used_bytes, input ready);
    modport sink   (input valid, status, result_index, free_bytes, used_bytes, output ready);
endinterface

// ===== rtl/core/bth_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module bth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/bth_seq.sv =====
// Allocator sequencer: tag walks, neighbor checks, clearing and tag writes.
// Depends on bth_pkg; drives the tag RAM port.
module bth_seq import bth_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  bth_req_t        req,
    output bth_done_t       done,
    input  logic            done_ack,
    output logic            ram_we,
    output logic [AW-1:0]   ram_addr,
    output logic [TW-1:0]   ram_wdata,
    input  logic [TW-1:0]   ram_rdata
);
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A_RD  = 4'd2;
    localparam logic [3:0] S_A_CHK = 4'd3;
    localparam logic [3:0] S_V_RD  = 4'd4;
    localparam logic [3:0] S_V_CHK = 4'd5;
    localparam logic [3:0] S_U_RD  = 4'd6;
    localparam logic [3:0] S_U_CHK = 4'd7;
    localparam logic [3:0] S_L_RD  = 4'd8;
    localparam logic [3:0] S_L_CHK = 4'd9;
    localparam logic [3:0] S_Z     = 4'd10;
    localparam logic [3:0] S_WQ    = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    localparam logic [XW-1:0] LAST = XW'(HEAP_WORDS - 1);
    localparam logic [XW-1:0] HW   = XW'(HEAP_WORDS);

    logic [3:0]      state_reg, state_next;
    logic [CMDW-1:0] cmd_reg, cmd_next;
    logic [BW-1:0]   bytes_reg, bytes_next;
    logic [AW-1:0]   p_reg, p_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [XW-1:0]   i_reg, i_next;
    logic [XW-1:0]   s_reg, s_next;
    logic [XW-1:0]   up_reg, up_next;
    logic [XW-1:0]   clr_reg, clr_next;
    logic [AW-1:0]   wq_addr_reg [4];
    logic [AW-1:0]   wq_addr_next [4];
    logic [TW-1:0]   wq_data_reg [4];
    logic [TW-1:0]   wq_data_next [4];
    logic [1:0]      wq_last_reg, wq_last_next;
    logic [1:0]      wq_ptr_reg, wq_ptr_next;
    logic            init_reg, init_next;
    logic            rel_reg, rel_next;
    logic            go_rel_reg, go_rel_next;
    logic            st_reg, st_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   free_reg, free_next;
    logic [CW-1:0]   used_reg, used_next;

    logic            tneg, tpos;
    logic [XW-1:0]   tx, tmag;
    logic [XW-1:0]   p_x, sum_i, lo_c, top_c, bot_c, tot_c, rel_w, grow_w, b1;
    logic            found;
    logic [BW:0]     n_raw;

    assign tneg  = ram_rdata[TW-1];
    assign tpos  = !tneg && (ram_rdata != '0);
    assign tx    = {{(XW-TW){ram_rdata[TW-1]}}, ram_rdata};
    assign tmag  = tneg ? (~tx + XW'(1)) : tx;
    assign p_x   = XW'(p_reg);
    assign sum_i = i_reg + tmag + XW'(1);
    assign found = tneg && ((18'(tmag) << 2) >= 18'(bytes_reg)) && (sum_i < HW);
    assign b1    = p_x + s_reg + XW'(1);
    assign lo_c  = ((b1 < HW) && tneg && (b1 + XW'(1) + tmag < HW)) ? tmag + XW'(2) : '0;
    assign top_c = p_x - XW'(1) - up_reg;
    assign bot_c = p_x + s_reg + lo_c;
    assign tot_c = s_reg + up_reg + lo_c;
    assign rel_w = s_reg + ((up_reg != '0) ? XW'(2) : '0) + ((lo_c != '0) ? XW'(2) : '0);
    assign grow_w = ((up_reg != '0) ? up_reg - XW'(2) : '0)
                  + ((lo_c != '0) ? lo_c - XW'(2) : '0);
    assign n_raw = {1'b0, req.byte_count} + (BW+1)'(3);

    assign req_ready   = (state_reg == S_IDLE);
    assign done.valid  = (state_reg == S_FIN);
    assign done.status = st_reg;
    assign done.idx    = idx_reg;
    assign done.free_b = free_reg;
    assign done.used_b = used_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        bytes_next  = bytes_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        s_next      = s_reg;
        up_next     = up_reg;
        clr_next    = clr_reg;
        wq_addr_next = wq_addr_reg;
        wq_data_next = wq_data_reg;
        wq_last_next = wq_last_reg;
        wq_ptr_next = wq_ptr_reg;
        init_next   = init_reg;
        rel_next    = rel_reg;
        go_rel_next = go_rel_reg;
        st_next     = st_reg;
        idx_next    = idx_reg;
        free_next   = free_reg;
        used_next   = used_reg;
        ram_we      = 1'b0;
        ram_addr    = '0;
        ram_wdata   = '0;

        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg[AW-1:0];
                ram_wdata = ((clr_reg == '0) || (clr_reg == LAST)) ? INIT_TAG : '0;
                clr_next  = clr_reg + XW'(1);
                if (clr_reg == LAST)
                begin
                    state_next = init_reg ? S_FIN : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next    = req.cmd;
                    bytes_next  = req.byte_count;
                    p_next      = req.payload_index;
                    n_next      = n_raw[BW:2];
                    rel_next    = 1'b0;
                    go_rel_next = 1'b0;
                    st_next     = 1'b1;
                    idx_next    = '0;
                    i_next      = '0;
                    unique case (req.cmd)
                        CMD_INIT:
                        begin
                            init_next  = 1'b1;
                            clr_next   = '0;
                            st_next    = 1'b0;
                            free_next  = FREE_INIT;
                            used_next  = USED_INIT;
                            state_next = S_CLR;
                        end
                        CMD_ALLOC:
                        begin
                            state_next = (req.byte_count == '0) ? S_FIN : S_A_RD;
                        end
                        default:
                        begin
                            state_next = (req.payload_index == '0) ? S_FIN : S_V_RD;
                        end
                    endcase
                end
            end
            S_A_RD:
            begin
                ram_addr   = i_reg[AW-1:0];
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (found)
                begin
                    st_next  = 1'b0;
                    idx_next = AW'(i_reg + XW'(1));
                    wq_ptr_next = '0;
                    wq_addr_next[0] = i_reg[AW-1:0];
                    if (16'(tmag) < 16'(n_reg) + 16'd3)
                    begin
                        wq_data_next[0] = tmag[TW-1:0];
                        wq_addr_next[1] = sum_i[AW-1:0];
                        wq_data_next[1] = tmag[TW-1:0];
                        wq_last_next    = 2'd1;
                        free_next = free_reg - {tmag[CW-3:0], 2'b00};
                        used_next = used_reg + {tmag[CW-3:0], 2'b00};
                    end
                    else
                    begin
                        wq_data_next[0] = n_reg[TW-1:0];
                        wq_addr_next[1] = AW'(i_reg + XW'(n_reg) + XW'(1));
                        wq_data_next[1] = n_reg[TW-1:0];
                        wq_addr_next[2] = AW'(i_reg + XW'(n_reg) + XW'(2));
                        wq_data_next[2] = TW'(XW'(n_reg) + XW'(2) - tmag);
                        wq_addr_next[3] = sum_i[AW-1:0];
                        wq_data_next[3] = TW'(XW'(n_reg) + XW'(2) - tmag);
                        wq_last_next    = 2'd3;
                        free_next = free_reg - {CW'(n_reg + NW'(2))} * CW'(4);
                        used_next = used_reg + {CW'(n_reg + NW'(2))} * CW'(4);
                    end
                    if (cmd_reg == CMD_RESIZE)
                    begin
                        rel_next    = 1'b1;
                        go_rel_next = 1'b1;
                    end
                    state_next = S_WQ;
                end
                else if (i_reg + tmag + XW'(2) < LAST)
                begin
                    i_next     = i_reg + tmag + XW'(2);
                    state_next = S_A_RD;
                end
                else
                begin
                    st_next    = 1'b1;
                    idx_next   = '0;
                    state_next = S_FIN;
                end
            end
            S_V_RD:
            begin
                ram_addr    = AW'(p_x - XW'(1));
                go_rel_next = 1'b0;
                state_next  = S_V_CHK;
            end
            S_V_CHK:
            begin
                s_next = tx;
                priority if (!tpos || (p_x + tx > LAST))
                begin
                    state_next = S_FIN;
                end
                else if (!rel_reg && (cmd_reg == CMD_RESIZE) && (NW'(tx) >= n_reg))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_U_RD;
                end
            end
            S_U_RD:
            begin
                ram_addr   = AW'(p_x - XW'(2));
                state_next = S_U_CHK;
            end
            S_U_CHK:
            begin
                up_next = ((p_x >= XW'(2)) && tneg && (p_x >= XW'(3) + tmag))
                          ? tmag + XW'(2) : '0;
                state_next = S_L_RD;
            end
            S_L_RD:
            begin
                ram_addr   = b1[AW-1:0];
                state_next = S_L_CHK;
            end
            S_L_CHK:
            begin
                wq_ptr_next     = '0;
                wq_last_next    = 2'd1;
                wq_addr_next[0] = top_c[AW-1:0];
                wq_addr_next[1] = bot_c[AW-1:0];
                if ((cmd_reg == CMD_RELEASE) || rel_reg)
                begin
                    wq_data_next[0] = TW'(~tot_c + XW'(1));
                    wq_data_next[1] = TW'(~tot_c + XW'(1));
                    free_next = free_reg + {rel_w[CW-3:0], 2'b00};
                    used_next = used_reg - {rel_w[CW-3:0], 2'b00};
                    clr_next  = top_c + XW'(1);
                    st_next   = 1'b0;
                    if (!rel_reg)
                    begin
                        idx_next = '0;
                    end
                    state_next = S_Z;
                end
                else if (16'(up_reg) + 16'(lo_c) >= 16'(n_reg) - 16'(s_reg))
                begin
                    wq_data_next[0] = tot_c[TW-1:0];
                    wq_data_next[1] = tot_c[TW-1:0];
                    free_next = free_reg - {grow_w[CW-3:0], 2'b00};
                    used_next = used_reg + {grow_w[CW-3:0], 2'b00};
                    st_next   = 1'b0;
                    idx_next  = AW'(top_c + XW'(1));
                    state_next = S_WQ;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_A_RD;
                end
            end
            S_Z:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg[AW-1:0];
                ram_wdata = '0;
                clr_next  = clr_reg + XW'(1);
                if (clr_reg + XW'(1) >= XW'(wq_addr_reg[1]))
                begin
                    state_next = S_WQ;
                end
            end
            S_WQ:
            begin
                ram_we      = 1'b1;
                ram_addr    = wq_addr_reg[wq_ptr_reg];
                ram_wdata   = wq_data_reg[wq_ptr_reg];
                wq_ptr_next = wq_ptr_reg + 2'd1;
                if (wq_ptr_reg == wq_last_reg)
                begin
                    state_next = go_rel_reg ? S_V_RD : S_FIN;
                end
            end
            S_FIN:
            begin
                if (done_ack)
                begin
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            init_reg   <= 1'b0;
            rel_reg    <= 1'b0;
            go_rel_reg <= 1'b0;
            free_reg   <= FREE_INIT;
            used_reg   <= USED_INIT;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            init_reg   <= init_next;
            rel_reg    <= rel_next;
            go_rel_reg <= go_rel_next;
            free_reg   <= free_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        bytes_reg   <= bytes_next;
        p_reg       <= p_next;
        n_reg       <= n_next;
        i_reg       <= i_next;
        s_reg       <= s_next;
        up_reg      <= up_next;
        wq_addr_reg <= wq_addr_next;
        wq_data_reg <= wq_data_next;
        wq_last_reg <= wq_last_next;
        wq_ptr_reg  <= wq_ptr_next;
        st_reg      <= st_next;
        idx_reg     <= idx_next;
    end
endmodule

// ===== rtl/core/boundary_tag_heap_allocator.sv =====
// Top level of the boundary-tag first-fit heap allocator.
// Depends on bth_pkg, bth_cmd_if, bth_res_if, bth_ram and bth_seq.
//
// Usage:
//   req carries one command word (init, allocate, release, resize) and rsp
//   returns exactly one result word per command: status, payload index and
//   the free and used byte counts after the command.
//   The tag heap lives in one 1024 x 11 single-port RAM; every tag access
//   goes through its one port in turn, so a command proceeds as follows:
//     allocate: a tag read and a check per block visited by the first-fit
//               walk, then 2 or 4 tag writes;
//     release:  neighbor checks, one write per interior word cleared in the
//               merged free block, then the two boundary tag writes;
//     resize:   in place, checks and 2 tag writes; else allocate plus release;
//     init:     a rewrite of the whole tag RAM.
//   One command is in flight at a time; req.ready is high while the
//   sequencer is idle, even while a finished result still sits in rsp.
// Reset: a clearing pass over all 1024 tag words writes the initial single free
//   block; req.ready stays low until it ends.
// Stall: a held rsp keeps its word; a newer result waits in the sequencer
//   until rsp frees up.
module boundary_tag_heap_allocator import bth_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    bth_cmd_if.sink  req,
    bth_res_if.source rsp
);
    bth_req_t      req_word;
    bth_done_t     done;
    logic          done_ack;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [TW-1:0] ram_wdata;
    logic [TW-1:0] ram_rdata;

    logic          out_valid_reg, out_valid_next;
    logic          status_reg;
    logic [AW-1:0] idx_reg;
    logic [CW-1:0] free_reg;
    logic [CW-1:0] used_reg;

    assign req_word.cmd           = req.cmd;
    assign req_word.byte_count    = req.byte_count;
    assign req_word.payload_index = req.payload_index;

    // take a finished result when the output register is empty or draining
    assign done_ack       = done.valid && (!out_valid_reg || rsp.ready);
    assign out_valid_next = done_ack ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    bth_ram #(
        .WIDTH (TW),
        .DEPTH (HEAP_WORDS)
    ) u_tags (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bth_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (req_word),
        .done      (done),
        .done_ack  (done_ack),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result word until it is taken
    always_ff @(posedge clk)
    begin
        if (done_ack)
        begin
            status_reg <= done.status;
            idx_reg    <= done.idx;
            free_reg   <= done.free_b;
            used_reg   <= done.used_b;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.result_index = idx_reg;
    assign rsp.free_bytes   = free_reg;
    assign rsp.used_bytes   = used_reg;
endmodule

// ===== sim/tb_boundary_tag_heap_allocator.sv =====
// Testbench for the boundary-tag first-fit heap allocator: random and directed
// commands checked against an internal heap predictor. Depends on bth_pkg,
// bth_cmd_if, bth_res_if and the allocator RTL.

class heap_scoreboard;
    typedef struct packed {
        logic                      status;
        logic [bth_pkg::AW-1:0]    idx;
        logic [bth_pkg::CW-1:0]    free_b;
        logic [bth_pkg::CW-1:0]    used_b;
    } heap_result_t;

    int           tags[bth_pkg::HEAP_WORDS];
    int unsigned  free_cnt;
    int unsigned  used_cnt;
    heap_result_t pending[$];
    int           errors;

    function new();
        errors = 0;
        heap_reset();
    endfunction

    function void heap_reset();
        foreach (tags[k]) tags[k] = 0;
        tags[0] = -(bth_pkg::HEAP_WORDS - 2);
        tags[bth_pkg::HEAP_WORDS-1] = -(bth_pkg::HEAP_WORDS - 2);
        free_cnt = ((bth_pkg::HEAP_WORDS - 2) * 4) & 13'h1FFF;
        used_cnt = 8;
    endfunction

    function void to_used(int unsigned w);
        free_cnt = (free_cnt - w * 4) & 13'h1FFF;
        used_cnt = (used_cnt + w * 4) & 13'h1FFF;
    endfunction

    function void to_free(int unsigned w);
        free_cnt = (free_cnt + w * 4) & 13'h1FFF;
        used_cnt = (used_cnt - w * 4) & 13'h1FFF;
    endfunction

    // first-fit walk; returns 1 and the payload index on success
    function bit first_fit(int unsigned bytes, output int unsigned idx);
        int unsigned i, n, s;
        int t;
        i = 0;
        idx = 0;
        if (bytes == 0) return 0;
        n = (bytes + 3) / 4;
        while (i < bth_pkg::HEAP_WORDS - 1) begin
            t = tags[i];
            if (t < 0) begin
                s = -t;
                if (s * 4 >= bytes && i + s + 1 < bth_pkg::HEAP_WORDS) begin
                    if (s < n + 3) begin
                        tags[i] = s;
                        tags[i+s+1] = s;
                        to_used(s);
                    end
                    else begin
                        tags[i] = n;
                        tags[i+n+1] = n;
                        tags[i+n+2] = -int'(s - n - 2);
                        tags[i+s+1] = -int'(s - n - 2);
                        to_used(n + 2);
                    end
                    idx = i + 1;
                    return 1;
                end
            end
            i += ((t < 0) ? -t : t) + 2;
        end
        return 0;
    endfunction

    function bit block_ok(int unsigned p, output int unsigned s);
        int t;
        s = 0;
        if (p < 1 || p >= bth_pkg::HEAP_WORDS) return 0;
        t = tags[p-1];
        if (t <= 0 || p + t > bth_pkg::HEAP_WORDS - 1) return 0;
        s = t;
        return 1;
    endfunction

    function int unsigned free_above(int unsigned p);
        int unsigned ts;
        if (p < 2 || tags[p-2] >= 0) return 0;
        ts = -tags[p-2];
        return (p >= 3 + ts) ? ts + 2 : 0;
    endfunction

    function int unsigned free_below(int unsigned b);
        int unsigned bs;
        if (b + 1 >= bth_pkg::HEAP_WORDS || tags[b+1] >= 0) return 0;
        bs = -tags[b+1];
        return (b + 2 + bs < bth_pkg::HEAP_WORDS) ? bs + 2 : 0;
    endfunction

    function bit release_block(int unsigned p);
        int unsigned s, up, lo, top, bot;
        if (!block_ok(p, s)) return 0;
        up = free_above(p);
        lo = free_below(p + s);
        top = p - 1 - up;
        bot = p + s + lo;
        to_free(s + (up ? 2 : 0) + (lo ? 2 : 0));
        for (int unsigned k = top + 1; k < bot; k++) tags[k] = 0;
        tags[top] = -int'(s + up + lo);
        tags[bot] = -int'(s + up + lo);
        return 1;
    endfunction

    function bit resize_block(int unsigned p, int unsigned bytes, output int unsigned idx);
        int unsigned s, n, up, lo, top, bot;
        idx = 0;
        if (!block_ok(p, s)) return 0;
        n = (bytes + 3) / 4;
        if (n <= s) return 0;
        up = free_above(p);
        lo = free_below(p + s);
        if (up + lo >= n - s) begin
            top = p - 1 - up;
            bot = p + s + lo;
            tags[top] = s + up + lo;
            tags[bot] = s + up + lo;
            to_used((up ? up - 2 : 0) + (lo ? lo - 2 : 0));
            idx = top + 1;
            return 1;
        end
        if (!first_fit(bytes, idx)) return 0;
        void'(release_block(p));
        return 1;
    endfunction

    // note an accepted command word and queue its expected result
    function void note_command(logic [1:0] cmd, int unsigned bytes, int unsigned p);
        heap_result_t r;
        int unsigned idx;
        bit ok;
        idx = 0;
        case (cmd)
            bth_pkg::CMD_INIT:    begin heap_reset(); ok = 1; end
            bth_pkg::CMD_ALLOC:   ok = first_fit(bytes, idx);
            bth_pkg::CMD_RELEASE: ok = release_block(p);
            default:              ok = resize_block(p, bytes, idx);
        endcase
        if (!ok) idx = 0;
        r.status = !ok;
        r.idx    = idx;
        r.free_b = free_cnt;
        r.used_b = used_cnt;
        pending.push_back(r);
    endfunction

    // compare an accepted result word with the oldest expectation
    function void check_result(heap_result_t got);
        heap_result_t exp;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", got);
            return;
        end
        exp = pending.pop_front();
        if (got !== exp) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                         exp.status, exp.idx, exp.free_b, exp.used_b,
                         got.status, got.idx, got.free_b, got.used_b);
        end
    endfunction
endclass

module tb_boundary_tag_heap_allocator;
    import bth_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;

    bth_cmd_if req();
    bth_res_if rsp();

    boundary_tag_heap_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    heap_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    // payload indexes handed out so far; release and resize mostly reuse them
    int unsigned live_blocks[$];

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // sample both channels at the rising edge; feed the predictor in accept order
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req.valid && req.ready) begin
                board.note_command(req.cmd, req.byte_count, req.payload_index);
                if (board.pending[$].status == 1'b0 &&
                    (req.cmd == CMD_ALLOC || req.cmd == CMD_RESIZE))
                    live_blocks.push_back(board.pending[$].idx);
                if (req.cmd == CMD_INIT) live_blocks.delete();
            end
            if (rsp.valid && rsp.ready) begin
                board.check_result({rsp.status, rsp.result_index,
                                    rsp.free_bytes, rsp.used_bytes});
            end
        end
    end

    // watchdog: count cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver: drive a random ready at the falling edge
    always @(negedge clk)
    begin
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // present one command word and hold it until accepted
    task automatic send_word(logic [1:0] cmd, int unsigned bytes, int unsigned p);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid         = 1'b1;
        req.cmd           = cmd;
        req.byte_count    = bytes[15:0];
        req.payload_index = p[9:0];
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge clk);
    endtask

    function automatic int unsigned pick_block();
        if (live_blocks.size() == 0 || $urandom_range(9) == 0)
            return $urandom_range(1023);
        return live_blocks[$urandom_range(live_blocks.size() - 1)];
    endfunction

    // one random command, biased toward realistic allocator traffic
    task automatic random_word();
        int unsigned sel;
        int unsigned bytes;
        sel = $urandom_range(99);
        if ($urandom_range(19) == 0) bytes = $urandom_range(65535);
        else if ($urandom_range(3) == 0) bytes = $urandom_range(1024);
        else bytes = $urandom_range(96);
        if (sel < 1)       send_word(CMD_INIT, $urandom_range(65535), $urandom_range(1023));
        else if (sel < 45) send_word(CMD_ALLOC, bytes, $urandom_range(1023));
        else if (sel < 80) send_word(CMD_RELEASE, $urandom_range(65535), pick_block());
        else               send_word(CMD_RESIZE, bytes, pick_block());
    endtask

    initial
    begin
        board = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = CMD_INIT;
        req.byte_count = '0;
        req.payload_index = '0;
        rsp.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, every command and the corner cases
        send_word(CMD_ALLOC, 0, 0);          // zero bytes fails
        send_word(CMD_ALLOC, 65535, 1023);   // no room
        send_word(CMD_ALLOC, 4088, 0);       // whole heap, no split
        send_word(CMD_RELEASE, 0, 1);
        send_word(CMD_ALLOC, 1, 0);          // one word
        send_word(CMD_ALLOC, 4, 0);
        send_word(CMD_ALLOC, 9, 0);
        send_word(CMD_RELEASE, 0, 4);        // middle block, no free neighbor
        send_word(CMD_RESIZE, 20, 1);        // freed neighbor too small, so it moves
        send_word(CMD_RESIZE, 0, 1);         // block at 1 is free now, fails
        send_word(CMD_RELEASE, 0, 0);        // invalid index
        send_word(CMD_RELEASE, 0, 1023);     // invalid index at top
        send_word(CMD_RELEASE, 0, 2);        // interior word, not a block
        send_word(CMD_RESIZE, 4000, 1);      // grow elsewhere fails or moves
        send_word(CMD_RESIZE, 800, 7);
        send_word(CMD_RELEASE, 0, 1);
        send_word(CMD_ALLOC, 4076, 0);       // no free block large enough
        send_word(CMD_INIT, 65535, 1023);
        send_word(CMD_RESIZE, 65535, 1);
        drain();

        // random phases: receiver idles, then sender idles, then neither
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 81 : 0;
            recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 32 : 0;
            for (int k = 0; k < 345; k++) begin
                random_word();
                if (k == 170) drain();       // hold off until all results are in
            end
        end

        drain();
        repeat (2000) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/bth_pkg.sv
rtl/core/bth_cmd_if.sv
rtl/core/bth_res_if.sv
rtl/core/bth_ram.sv
rtl/core/bth_seq.sv
rtl/core/boundary_tag_heap_allocator.sv
sim/tb_boundary_tag_heap_allocator.sv
